// ===== rtl/core/modexp_pkg.sv =====
// modexp_pkg: shared constants and control structs for the modular exponentiation block
// no dependencies
`default_nettype none
package modexp_pkg;
  localparam int OPERAND_BITS_DEF = 31;
  localparam int RESULT_BITS      = 31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED,
    ST_MUL,
    ST_SQR,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic go;
  } mm_req_t;

  typedef struct packed {
    logic done;
    logic busy;
  } mm_stat_t;
endpackage
`default_nettype wire

// ===== rtl/core/modexp_mulmod.sv =====
// modexp_mulmod: bit-serial interleaved modular multiplier, one bit of x per cycle
// depends on modexp_pkg; requires a <= m and m != 0
`default_nettype none
module modexp_mulmod import modexp_pkg::*; #(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire mm_req_t                 req,
  input  wire logic [OPERAND_BITS-1:0] x,
  input  wire logic [OPERAND_BITS-1:0] a,
  input  wire logic [OPERAND_BITS-1:0] m,
  output mm_stat_t                     stat,
  output logic [OPERAND_BITS-1:0]      res
);
  localparam int CW = $clog2(OPERAND_BITS + 1);
  localparam int WW = OPERAND_BITS + 2;

  logic [OPERAND_BITS-1:0] r_r, r_nxt, x_r, a_r, m_r;
  logic [CW-1:0]           cnt_r;
  logic                    run_r, done_r;
  logic [WW-1:0]           t0, t1, u0, u1, mw;

  always_comb begin
    mw = WW'(m_r);
    t0 = {1'b0, r_r, 1'b0};
    t1 = (t0 >= mw) ? t0 - mw : t0;
    u0 = t1 + (x_r[OPERAND_BITS-1] ? WW'(a_r) : '0);
    u1 = (u0 >= mw) ? u0 - mw : u0;
    r_nxt = u1[OPERAND_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        run_r <= 1'b1;
        cnt_r <= CW'(OPERAND_BITS);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      r_r <= '0;
      x_r <= x;
      a_r <= a;
      m_r <= m;
    end else if (run_r) begin
      r_r <= r_nxt;
      x_r <= {x_r[OPERAND_BITS-2:0], 1'b0};
    end
  end

  assign stat.done = done_r;
  assign stat.busy = run_r;
  assign res       = r_r;
endmodule
`default_nettype wire

// ===== rtl/core/modular_exponentiation_top.sv =====
// modular_exponentiation_top: right-to-left square-and-multiply sequencer
// depends on modexp_pkg and modexp_mulmod
//
// channel  ports                                    dir  handshake
// input    in_base, in_exponent, in_modulus         in   start & !busy
// result   out_power_result, out_zero_modulus_error out  out_strobe, one cycle
//
// one shared bit-serial mulmod unit computes every product
// a word takes 1 + ones(e) + max(bitlen(e)-1, 0) products,
// at most about 2*OPERAND_BITS products
// zero modulus goes straight to ST_FIN; busy stays high until the strobe cycle ends
// synchronous active-low reset returns to idle; the receiver cannot stall
`default_nettype none
module modular_exponentiation_top import modexp_pkg::*; #(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [OPERAND_BITS-1:0] in_base,
  input  wire logic [OPERAND_BITS-1:0] in_exponent,
  input  wire logic [OPERAND_BITS-1:0] in_modulus,
  output logic                         out_strobe,
  output logic [RESULT_BITS-1:0]       out_power_result,
  output logic                         out_zero_modulus_error
);
  state_t state_r, state_nxt;

  // operand registers
  logic [OPERAND_BITS-1:0] e_r, m_r, acc_r, sq_r;
  logic                    err_r;
  logic [OPERAND_BITS-1:0] e_sh;

  mm_req_t                 mm_req;
  mm_stat_t                mm_stat;
  logic [OPERAND_BITS-1:0] mm_x, mm_a, mm_res;

  logic accept;
  assign accept = start && (state_r == ST_IDLE);
  assign e_sh   = e_r >> 1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = (in_modulus == '0) ? ST_FIN : ST_RED;
      ST_RED: if (mm_stat.done) begin
        if (e_r == '0)   state_nxt = ST_FIN;
        else if (e_r[0]) state_nxt = ST_MUL;
        else             state_nxt = ST_SQR;
      end
      ST_MUL: if (mm_stat.done) state_nxt = (e_sh == '0) ? ST_FIN : ST_SQR;
      ST_SQR: if (mm_stat.done) state_nxt = e_sh[0] ? ST_MUL : ST_SQR;
      ST_FIN: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // unit launch and operand select
  always_comb begin
    mm_req.go = 1'b0;
    mm_x      = sq_r;
    mm_a      = sq_r;
    unique case (state_r)
      ST_IDLE: begin
        // base mod m, fed as base times one
        mm_req.go = accept && (in_modulus != '0);
        mm_x      = in_base;
        mm_a      = OPERAND_BITS'(1);
      end
      ST_RED: begin
        mm_req.go = mm_stat.done && (e_r != '0);
        mm_x      = e_r[0] ? acc_r : mm_res;
        mm_a      = mm_res;
      end
      ST_MUL: begin
        mm_req.go = mm_stat.done && (e_sh != '0);
        mm_x      = sq_r;
        mm_a      = sq_r;
      end
      ST_SQR: begin
        mm_req.go = mm_stat.done;
        mm_x      = e_sh[0] ? acc_r : mm_res;
        mm_a      = mm_res;
      end
      ST_FIN: mm_req.go = 1'b0;
      default: mm_req.go = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: if (accept) begin
        e_r   <= in_exponent;
        m_r   <= in_modulus;
        err_r <= (in_modulus == '0);
        acc_r <= (in_modulus == '0) ? '0 : OPERAND_BITS'(1);
      end
      ST_RED: if (mm_stat.done) sq_r <= mm_res;
      ST_MUL: if (mm_stat.done) acc_r <= mm_res;
      ST_SQR: if (mm_stat.done) begin
        sq_r <= mm_res;
        e_r  <= e_sh;
      end
      ST_FIN: ;
      default: ;
    endcase
  end

  modexp_mulmod #(.OPERAND_BITS(OPERAND_BITS)) u_mulmod (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mm_req),
    .x    (mm_x),
    .a    (mm_a),
    .m    ((state_r == ST_IDLE) ? in_modulus : m_r),
    .stat (mm_stat),
    .res  (mm_res)
  );

  assign busy                   = (state_r != ST_IDLE);
  assign out_strobe             = (state_r == ST_FIN);
  assign out_power_result       = RESULT_BITS'(acc_r);
  assign out_zero_modulus_error = err_r;

  // checks
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_zero_modulus_error |-> out_power_result == '0)
    else $error("error result not zero");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("strobe longer than one cycle");
  a_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mm_req.go |-> !mm_stat.busy)
    else $error("unit relaunched while running");
endmodule
`default_nettype wire
